@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ihc_pkg.sv @@
// ---------------------------------------------------------------------------
// IPv4 header checker package
// Verdict codes, header constants, shared structs and the checksum adder.
// ---------------------------------------------------------------------------
package ihc_pkg;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT      = 3'd0,
    VERDICT_BAD_VERSION = 3'd1,
    VERDICT_SHORT_HDR   = 3'd2,
    VERDICT_CSUM_ERR    = 3'd3,
    VERDICT_LEN_ERR     = 3'd4,
    VERDICT_ICMP_DROP   = 3'd5
  } verdict_t;

  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  MIN_IHL    = 4'd5;
  localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  // Everything the verdict logic needs once the last header word is in.
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] total;
    logic [15:0] buffer_len;
    logic [7:0]  proto;
    logic [4:0]  words_expected;
  } summary_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [5:0]  header_bytes;
    logic [7:0]  protocol;
    logic [15:0] total_bytes;
    logic [15:0] trim_bytes;
  } result_t;

  // Ones'-complement add with end-around carry; one fold is enough.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

@@ hw/rtl/ihc_verdict.sv @@
// ---------------------------------------------------------------------------
// IPv4 header checker verdict logic
// Turns the summary of a complete header into a verdict and trim length.
// ---------------------------------------------------------------------------
module ihc_verdict (
  input  ihc_pkg::summary_t summary,
  output ihc_pkg::result_t  result
);

  logic [5:0]  hb;
  logic [15:0] hb_wide;

  assign hb      = {summary.words_expected, 1'b0};
  assign hb_wide = {10'd0, hb};

  always_comb begin
    result.header_bytes = hb;
    result.protocol     = summary.proto;
    result.total_bytes  = summary.total;
    result.trim_bytes   = 16'd0;
    priority if (summary.sum != ihc_pkg::SUM_GOOD) begin
      result.verdict = ihc_pkg::VERDICT_CSUM_ERR;
    end else if ((summary.buffer_len < summary.total) || (summary.total < hb_wide)) begin
      result.verdict = ihc_pkg::VERDICT_LEN_ERR;
    end else begin
      // Buffer is at least as long as the datagram here, so no underflow.
      result.trim_bytes = summary.buffer_len - summary.total;
      if (summary.proto == ihc_pkg::PROTO_ICMP) begin
        result.verdict = ihc_pkg::VERDICT_ICMP_DROP;
      end else begin
        result.verdict = ihc_pkg::VERDICT_ACCEPT;
      end
    end
  end

endmodule

@@ hw/rtl/ipv4_header_checker_core.sv @@
// ---------------------------------------------------------------------------
// IPv4 header checker core
// A verdict appears in the output register in the cycle after the item that
// completes it (the first word for a bad version or short header).
// Throughput: one header word per cycle unless a result waits on out_tready,
// set by the running checksum add and the output register between channels.
// Reset: synchronous active-low rst_n clears the packet state and out_tvalid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_header_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] header_word, [31:16] buffer_length
  input  logic [0:0]  in_tuser,   // [0] first_word
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [2:0] verdict, [8:3] header_bytes, [16:9] protocol,
                                  // [32:17] total_bytes, [48:33] trim_bytes, rest zero
);

  // Packet state. The accumulator and counters follow the header word by
  // word; the length and protocol fields are captured as they pass.
  logic [15:0] sum_r, sum_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [4:0]  exp_r, exp_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] blen_r, blen_nxt;
  logic [7:0]  proto_r, proto_nxt;

  // Output register.
  logic              out_valid_r;
  ihc_pkg::result_t  out_res_r;

  logic              in_acc;
  logic [15:0]       word;
  logic [15:0]       buf_len;
  logic              first;
  logic [3:0]        version;
  logic [3:0]        ihl;
  logic              fire;
  ihc_pkg::result_t  res;
  ihc_pkg::summary_t summary;
  ihc_pkg::result_t  final_res;

  // A new item is taken whenever the output register is empty or is being
  // emptied in this cycle, so a waiting result never stalls the stream
  // for longer than the downstream side holds it.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign word    = in_tdata[15:0];
  assign buf_len = in_tdata[31:16];
  assign first   = in_tuser[0];
  assign version = word[15:12];
  assign ihl     = word[11:8];

  // The verdict logic sees the state as it stands after this word, so the
  // last word's checksum contribution is included.
  assign summary.sum            = sum_nxt;
  assign summary.total          = total_nxt;
  assign summary.buffer_len     = blen_r;
  assign summary.proto          = proto_nxt;
  assign summary.words_expected = exp_r;

  ihc_verdict u_verdict (
    .summary (summary),
    .result  (final_res)
  );

  always_comb begin
    sum_nxt   = sum_r;
    seen_nxt  = seen_r;
    exp_nxt   = exp_r;
    busy_nxt  = busy_r;
    total_nxt = total_r;
    blen_nxt  = blen_r;
    proto_nxt = proto_r;
    fire      = 1'b0;
    res       = final_res;
    if (in_acc) begin
      if (first) begin
        // A first word always drops any open packet; it opens a new one only if its version and length are good.
        busy_nxt  = 1'b0;
        sum_nxt   = word;
        seen_nxt  = 5'd1;
        exp_nxt   = {ihl, 1'b0};
        total_nxt = 16'd0;
        blen_nxt  = buf_len;
        proto_nxt = 8'd0;
        res.header_bytes = {ihl, 2'b00};
        res.protocol     = 8'd0;
        res.total_bytes  = 16'd0;
        res.trim_bytes   = 16'd0;
        priority if (version != ihc_pkg::IP_VERSION) begin
          fire        = 1'b1;
          res.verdict = ihc_pkg::VERDICT_BAD_VERSION;
        end else if (ihl < ihc_pkg::MIN_IHL) begin
          // A header shorter than the fixed part is dropped at once.
          fire        = 1'b1;
          res.verdict = ihc_pkg::VERDICT_SHORT_HDR;
        end else begin
          busy_nxt = 1'b1;
        end
      end else if (busy_r) begin
        // The second word carries the total length, the fifth the protocol
        // in its low byte. Words outside an open packet are ignored.
        if (seen_r == 5'd1) begin
          total_nxt = word;
        end else if (seen_r == 5'd4) begin
          proto_nxt = word[7:0];
        end
        sum_nxt  = ihc_pkg::oc_add(sum_r, word);
        seen_nxt = 5'(seen_r + 5'd1);
        if (seen_nxt == exp_r) begin
          busy_nxt = 1'b0;
          fire     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= 16'd0;
      seen_r  <= 5'd0;
      exp_r   <= 5'd0;
      busy_r  <= 1'b0;
      total_r <= 16'd0;
      blen_r  <= 16'd0;
      proto_r <= 8'd0;
    end else begin
      sum_r   <= sum_nxt;
      seen_r  <= seen_nxt;
      exp_r   <= exp_nxt;
      busy_r  <= busy_nxt;
      total_r <= total_nxt;
      blen_r  <= blen_nxt;
      proto_r <= proto_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The payload is loaded only with a fresh result and needs no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.trim_bytes, out_res_r.total_bytes,
                       out_res_r.protocol, out_res_r.header_bytes, out_res_r.verdict};

  // An open packet never has counted all of its words.
  `ASSERT_IMP(a_busy_count, busy_r, seen_r < exp_r)
  // A stalled result blocks the input, so no result can be overwritten.
  `ASSERT_IMP(a_no_overrun, out_valid_r && !out_tready, !in_tready)
  // A bad version on a first word is reported in the next cycle.
  `ASSERT_NEXT(a_early_version,
               in_acc && first && (version != ihc_pkg::IP_VERSION),
               out_valid_r && (out_res_r.verdict == ihc_pkg::VERDICT_BAD_VERSION))
  // Only accepted or ICMP-dropped packets carry a trim length.
  `ASSERT_IMP(a_trim_zero,
              out_valid_r && (out_res_r.verdict != ihc_pkg::VERDICT_ACCEPT)
                && (out_res_r.verdict != ihc_pkg::VERDICT_ICMP_DROP),
              out_res_r.trim_bytes == 16'd0)

endmodule
